/* rtl/core/i2c_master_transfer_sequencer_top_assert.svh */
// Assertion macros for the I2C master transfer sequencer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset
`define I2CMTS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle
`define I2CMTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle
`define I2CMTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define I2CMTS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define I2CMTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define I2CMTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* rtl/core/i2cmts_pkg.sv */
// Shared types and constants for the I2C master transfer sequencer.
// No dependencies; imported by i2cmts_core and the top level.
package i2cmts_pkg;

    localparam int CNT_W      = 16;
    localparam int ADDR_W     = 8;
    localparam int DATA_W     = 8;
    localparam int CMD_W      = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register word indexes on the configuration port
    localparam logic [0:0] REG_NOTIFY_ENABLE = 1'b0;

    // Address byte direction masks
    localparam logic [ADDR_W-1:0] ADDR_READ_MASK  = 8'hFE;
    localparam logic [ADDR_W-1:0] ADDR_WRITE_BIT  = 8'h01;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ          = 4'd0,
        CMD_WRITE         = 4'd1,
        CMD_PROBE         = 4'd2,
        CMD_START_SENT    = 4'd3,
        CMD_TX_MODE       = 4'd4,
        CMD_TX_EMPTY      = 4'd5,
        CMD_BYTE_SENT     = 4'd6,
        CMD_RX_MODE       = 4'd7,
        CMD_BYTE_RECEIVED = 4'd8,
        CMD_IGNORED       = 4'd9,
        CMD_UNKNOWN       = 4'd10,
        CMD_PHY_ERROR     = 4'd11,
        CMD_BUS_ERROR     = 4'd12
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_START = 4'b0010,
        PH_TX    = 4'b0100,
        PH_RX    = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        ACK_KEEP    = 2'd0,
        ACK_ENABLE  = 2'd1,
        ACK_DISABLE = 2'd2
    } ack_t;

    typedef enum logic [2:0] {
        RES_PROBE_OK = 3'd0,
        RES_WRITE_OK = 3'd1,
        RES_READ_OK  = 3'd2,
        RES_PHY      = 3'd3,
        RES_UNKNOWN  = 3'd4
    } done_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] device_address;
        logic [CNT_W-1:0]  transfer_length;
        logic              stop_at_end;
        logic [DATA_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic              reply_code;
        logic              start_condition;
        logic              send_address;
        logic [ADDR_W-1:0] address_out;
        logic              send_byte;
        logic              store_byte;
        logic [DATA_W-1:0] byte_out;
        logic              generate_stop;
        ack_t              ack_action;
        logic              bus_reset;
        logic              done_res;
        done_t             done_result;
    } result_t;

endpackage

/* rtl/core/i2cmts_core.sv */
// Transfer state and per-item decision logic of the I2C master sequencer.
// Depends on i2cmts_pkg. State advances only when step is high.
module i2cmts_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  i2cmts_pkg::item_t   item,
    input  logic                notify_enable,
    output i2cmts_pkg::result_t result
);
    import i2cmts_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  remaining_reg, remaining_next;
    logic [ADDR_W-1:0] target_reg, target_next;
    logic              stop_flag_reg, stop_flag_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= '0;
            target_reg    <= '0;
            stop_flag_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            target_reg    <= target_next;
            stop_flag_reg <= stop_flag_next;
        end
    end

    // Decision logic for one item
    always_comb
    begin
        logic             fin;
        done_t            fin_code;
        logic             rem_zero;
        logic             rem_le1;
        logic             is_idle;
        logic [CNT_W-1:0] rem_dec;

        rem_zero = (remaining_reg == '0);
        rem_le1  = (remaining_reg <= CNT_W'(1));
        rem_dec  = remaining_reg - CNT_W'(1);
        is_idle  = (phase_reg == PH_IDLE);
        fin      = 1'b0;
        fin_code = RES_PROBE_OK;

        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        target_next    = target_reg;
        stop_flag_next = stop_flag_reg;
        result         = '0;

        case (item.command)
            CMD_READ, CMD_WRITE, CMD_PROBE:
            begin
                if (!is_idle)
                begin
                    result.reply_code = 1'b1;
                end
                else
                begin
                    phase_next             = PH_START;
                    result.start_condition = 1'b1;
                    if (item.command == CMD_READ)
                    begin
                        target_next       = item.device_address & ADDR_READ_MASK;
                        remaining_next    = item.transfer_length;
                        stop_flag_next    = item.stop_at_end;
                        result.ack_action = (item.transfer_length > CNT_W'(1))
                                            ? ACK_ENABLE : ACK_DISABLE;
                    end
                    else if (item.command == CMD_WRITE)
                    begin
                        target_next    = item.device_address | ADDR_WRITE_BIT;
                        remaining_next = item.transfer_length;
                        stop_flag_next = item.stop_at_end;
                    end
                    else
                    begin
                        // probe: empty write that always ends with a stop
                        target_next    = item.device_address | ADDR_WRITE_BIT;
                        remaining_next = '0;
                        stop_flag_next = 1'b1;
                    end
                end
            end
            CMD_START_SENT:
            begin
                result.send_address = 1'b1;
            end
            CMD_TX_MODE:
            begin
                if (!rem_zero)
                begin
                    phase_next       = PH_TX;
                    result.send_byte = 1'b1;
                    result.byte_out  = item.data_byte;
                    remaining_next   = rem_dec;
                end
                else
                begin
                    result.generate_stop = 1'b1;
                    fin                  = 1'b1;
                    fin_code             = RES_PROBE_OK;
                end
            end
            CMD_TX_EMPTY:
            begin
                if (!rem_zero)
                begin
                    result.send_byte = 1'b1;
                    result.byte_out  = item.data_byte;
                    remaining_next   = rem_dec;
                end
            end
            CMD_BYTE_SENT:
            begin
                if (!is_idle && rem_zero)
                begin
                    result.generate_stop = stop_flag_reg;
                    fin                  = 1'b1;
                    fin_code             = RES_WRITE_OK;
                end
            end
            CMD_RX_MODE:
            begin
                phase_next = PH_RX;
                if (rem_le1)
                begin
                    result.generate_stop = stop_flag_reg;
                    result.ack_action    = ACK_DISABLE;
                end
            end
            CMD_BYTE_RECEIVED:
            begin
                if (phase_reg == PH_RX)
                begin
                    if (!rem_zero)
                    begin
                        result.store_byte = 1'b1;
                        result.byte_out   = item.data_byte;
                        remaining_next    = rem_dec;
                    end
                    // last byte, or nothing left to take: close the read
                    if (rem_le1)
                    begin
                        result.generate_stop = stop_flag_reg;
                        result.ack_action    = ACK_DISABLE;
                        fin                  = 1'b1;
                        fin_code             = RES_READ_OK;
                    end
                end
            end
            CMD_IGNORED:
            begin
            end
            CMD_PHY_ERROR:
            begin
                if (!is_idle)
                begin
                    fin      = 1'b1;
                    fin_code = RES_PHY;
                end
            end
            CMD_BUS_ERROR:
            begin
                if (!is_idle)
                begin
                    result.bus_reset     = 1'b1;
                    result.generate_stop = 1'b1;
                    fin                  = 1'b1;
                    fin_code             = RES_PHY;
                end
            end
            default:
            begin
                // unknown event and unused codes abort with a bus reset
                if (!is_idle)
                begin
                    result.bus_reset     = 1'b1;
                    result.generate_stop = 1'b1;
                    fin                  = 1'b1;
                    fin_code             = RES_UNKNOWN;
                end
            end
        endcase

        // Completion or abort returns to idle, notification if enabled
        if (fin)
        begin
            phase_next = PH_IDLE;
            if (notify_enable)
            begin
                result.done_res    = 1'b1;
                result.done_result = fin_code;
            end
        end

        result.address_out = target_next;
    end

endmodule

/* rtl/core/i2c_master_transfer_sequencer_top.sv */
// I2C master transfer sequencer, top level: input register, decision core,
// result register and the configuration port. Depends on i2cmts_pkg and i2cmts_core.
//
// The block takes one item per clock cycle while in_stall is low and gives
// exactly one result item for each. An accepted item is held in the input
// register, the core decides and updates the transfer state, and the result
// is written to the result register when the item moves on (advance): only
// then does out_valid rise, and the result is taken when out_stall is low.
// The rate is set by the core's state loop (phase, byte count, address,
// stop flag), which the core updates at each edge where an item moves on. The result
// register lets the input side keep taking items while a result waits; the
// input stalls only when both registers are full and out_stall is high.
// notify_enable (word 0 of the configuration port) gates done_res.
`include "i2c_master_transfer_sequencer_top_assert.svh"

module i2c_master_transfer_sequencer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [i2cmts_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [i2cmts_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [i2cmts_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [i2cmts_pkg::CMD_W-1:0]       command,
    input  logic [i2cmts_pkg::ADDR_W-1:0]      device_address,
    input  logic [i2cmts_pkg::CNT_W-1:0]       transfer_length,
    input  logic                               stop_at_end,
    input  logic [i2cmts_pkg::DATA_W-1:0]      data_byte,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               reply_code,
    output logic                               start_condition,
    output logic                               send_address,
    output logic [i2cmts_pkg::ADDR_W-1:0]      address_out,
    output logic                               send_byte,
    output logic                               store_byte,
    output logic [i2cmts_pkg::DATA_W-1:0]      byte_out,
    output logic                               generate_stop,
    output logic [1:0]                         ack_action,
    output logic                               bus_reset,
    output logic                               done_res,
    output logic [2:0]                         done_result
);
    import i2cmts_pkg::*;

    logic    notify_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t core_res;
    logic    advance;
    logic    cfg_write;
    logic    word_sel;

    // Configuration port: always ready, one register at word 0
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign word_sel  = paddr[APB_ADDR_W-1];
    assign prdata    = (word_sel == REG_NOTIFY_ENABLE)
                       ? {{(APB_DATA_W-1){1'b0}}, notify_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            notify_reg <= 1'b0;
        else if (cfg_write && (word_sel == REG_NOTIFY_ENABLE))
            notify_reg <= pwdata[0];
    end

    // Handshake: the input register moves on when the result register is free or its result is taken
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg.command         <= command;
            in_item_reg.device_address  <= device_address;
            in_item_reg.transfer_length <= transfer_length;
            in_item_reg.stop_at_end     <= stop_at_end;
            in_item_reg.data_byte       <= data_byte;
        end
    end

    // Decision core with transfer state
    i2cmts_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .item          (in_item_reg),
        .notify_enable (notify_reg),
        .result        (core_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= core_res;
    end

    // Result fields
    assign out_valid       = out_valid_reg;
    assign reply_code      = out_res_reg.reply_code;
    assign start_condition = out_res_reg.start_condition;
    assign send_address    = out_res_reg.send_address;
    assign address_out     = out_res_reg.address_out;
    assign send_byte       = out_res_reg.send_byte;
    assign store_byte      = out_res_reg.store_byte;
    assign byte_out        = out_res_reg.byte_out;
    assign generate_stop   = out_res_reg.generate_stop;
    assign ack_action      = out_res_reg.ack_action;
    assign bus_reset       = out_res_reg.bus_reset;
    assign done_res        = out_res_reg.done_res;
    assign done_result     = out_res_reg.done_result;

    // Checks
    `I2CMTS_ASSERT_IMPL(a_stall_only_when_full, clk, rst_n, in_stall,
        out_valid_reg && out_stall && in_valid_reg, "input stalled with room downstream")
    `I2CMTS_ASSERT_IMPL(a_done_needs_notify, clk, rst_n, out_valid_reg && done_res,
        notify_reg, "done raised without notify enable")
    `I2CMTS_ASSERT_ALWAYS(a_busy_no_start, clk, rst_n,
        !(out_valid_reg && reply_code && start_condition), "busy reply with start request")
    `I2CMTS_ASSERT_NEXT(a_held_result, clk, rst_n, out_valid_reg && out_stall,
        out_valid_reg && $stable(out_res_reg), "stalled result lost or changed")

endmodule

/* tb/i2c_master_transfer_sequencer_top_tb.sv */
// Testbench for the I2C master transfer sequencer top level.
// Depends on i2cmts_pkg and the RTL of i2c_master_transfer_sequencer_top.
// A scoreboard class predicts every result; tasks drive items and the APB port.
`timescale 1ns / 100ps

module i2c_master_transfer_sequencer_top_tb;

    import i2cmts_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_BURST      = 24;
    // codes past the event table decode as the unknown event
    localparam logic [CMD_W-1:0] CMD_ABOVE_TABLE = 4'hF;

    // Transfer predictor and store of expected result items
    class xfer_scoreboard;
        phase_t            phase     = PH_IDLE;
        logic [CNT_W-1:0]  remaining = '0;
        logic [ADDR_W-1:0] target    = '0;
        logic              stop_flag = 1'b0;
        logic              notify    = 1'b0;
        result_t           expected_q[$];
        int                errors    = 0;

        function void set_notify(logic value);
            notify = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Transfer over: back to idle, raise done only when enabled
        function void close_transfer(inout result_t r, input done_t code);
            phase = PH_IDLE;
            if (notify) begin
                r.done_res    = 1'b1;
                r.done_result = code;
            end
        endfunction

        // Error events only matter while a transfer is open
        function void abort_transfer(inout result_t r, input done_t code, input logic reset_bus);
            if (phase != PH_IDLE) begin
                if (reset_bus) begin
                    r.bus_reset     = 1'b1;
                    r.generate_stop = 1'b1;
                end
                close_transfer(r, code);
            end
        endfunction

        function void note_input(item_t it);
            result_t r;
            r = '0;
            case (it.command)
                CMD_READ, CMD_WRITE, CMD_PROBE: begin
                    if (phase != PH_IDLE) begin
                        r.reply_code = 1'b1;
                    end else begin
                        phase             = PH_START;
                        r.start_condition = 1'b1;
                        if (it.command == CMD_READ) begin
                            target       = it.device_address & ADDR_READ_MASK;
                            remaining    = it.transfer_length;
                            stop_flag    = it.stop_at_end;
                            r.ack_action = (it.transfer_length > 1) ? ACK_ENABLE : ACK_DISABLE;
                        end else if (it.command == CMD_WRITE) begin
                            target    = it.device_address | ADDR_WRITE_BIT;
                            remaining = it.transfer_length;
                            stop_flag = it.stop_at_end;
                        end else begin
                            // probe: no data, always stop
                            target    = it.device_address | ADDR_WRITE_BIT;
                            remaining = '0;
                            stop_flag = 1'b1;
                        end
                    end
                end
                CMD_START_SENT: r.send_address = 1'b1;
                CMD_TX_MODE: begin
                    if (remaining > 0) begin
                        phase       = PH_TX;
                        r.send_byte = 1'b1;
                        r.byte_out  = it.data_byte;
                        remaining   = remaining - 1'b1;
                    end else begin
                        r.generate_stop = 1'b1;
                        close_transfer(r, RES_PROBE_OK);
                    end
                end
                CMD_TX_EMPTY: begin
                    if (remaining > 0) begin
                        r.send_byte = 1'b1;
                        r.byte_out  = it.data_byte;
                        remaining   = remaining - 1'b1;
                    end
                end
                CMD_BYTE_SENT: begin
                    if (phase != PH_IDLE && remaining == 0) begin
                        r.generate_stop = stop_flag;
                        close_transfer(r, RES_WRITE_OK);
                    end
                end
                CMD_RX_MODE: begin
                    phase = PH_RX;
                    if (remaining <= 1) begin
                        r.generate_stop = stop_flag;
                        r.ack_action    = ACK_DISABLE;
                    end
                end
                CMD_BYTE_RECEIVED: begin
                    if (phase == PH_RX) begin
                        if (remaining > 0) begin
                            r.store_byte = 1'b1;
                            r.byte_out   = it.data_byte;
                            remaining    = remaining - 1'b1;
                        end
                        // count exhausted: the read completes, extra byte dropped
                        if (remaining == 0) begin
                            r.generate_stop = stop_flag;
                            r.ack_action    = ACK_DISABLE;
                            close_transfer(r, RES_READ_OK);
                        end
                    end
                end
                CMD_IGNORED: ;
                CMD_PHY_ERROR: abort_transfer(r, RES_PHY, 1'b0);
                CMD_BUS_ERROR: abort_transfer(r, RES_PHY, 1'b1);
                default: abort_transfer(r, RES_UNKNOWN, 1'b1);
            endcase
            r.address_out = target;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0h, got %0h", field, want, seen);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                $error("result item with no item waiting");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("reply_code", want.reply_code, got.reply_code);
            compare_field("start_condition", want.start_condition, got.start_condition);
            compare_field("send_address", want.send_address, got.send_address);
            compare_field("address_out", want.address_out, got.address_out);
            compare_field("send_byte", want.send_byte, got.send_byte);
            compare_field("store_byte", want.store_byte, got.store_byte);
            compare_field("byte_out", want.byte_out, got.byte_out);
            compare_field("generate_stop", want.generate_stop, got.generate_stop);
            compare_field("ack_action", want.ack_action, got.ack_action);
            compare_field("bus_reset", want.bus_reset, got.bus_reset);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("done_result", want.done_result, got.done_result);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic [CMD_W-1:0]      command;
    logic [ADDR_W-1:0]     device_address;
    logic [CNT_W-1:0]      transfer_length;
    logic                  stop_at_end;
    logic [DATA_W-1:0]     data_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic                  reply_code;
    logic                  start_condition;
    logic                  send_address;
    logic [ADDR_W-1:0]     address_out;
    logic                  send_byte;
    logic                  store_byte;
    logic [DATA_W-1:0]     byte_out;
    logic                  generate_stop;
    logic [1:0]            ack_action;
    logic                  bus_reset;
    logic                  done_res;
    logic [2:0]            done_result;

    xfer_scoreboard board = new;
    logic           gaps_on   = 1'b1;
    logic           hold_go   = 1'b0;
    logic           hold_done = 1'b0;
    int             items_sent = 0;
    int             quiet_cycles = 0;

    i2c_master_transfer_sequencer_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .device_address  (device_address),
        .transfer_length (transfer_length),
        .stop_at_end     (stop_at_end),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .reply_code      (reply_code),
        .start_condition (start_condition),
        .send_address    (send_address),
        .address_out     (address_out),
        .send_byte       (send_byte),
        .store_byte      (store_byte),
        .byte_out        (byte_out),
        .generate_stop   (generate_stop),
        .ack_action      (ack_action),
        .bus_reset       (bus_reset),
        .done_res        (done_res),
        .done_result     (done_result)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one item, with random idle cycles ahead of it; returns at the accepting edge
    task automatic send_item(input item_t it);
        while (gaps_on && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        command         <= it.command;
        device_address  <= it.device_address;
        transfer_length <= it.transfer_length;
        stop_at_end     <= it.stop_at_end;
        data_byte       <= it.data_byte;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        board.note_input(it);
        items_sent++;
        @(posedge clk);
    endtask

    function automatic item_t rand_item(input logic [CMD_W-1:0] cmd);
        item_t it;
        it.command         = cmd;
        it.device_address  = ADDR_W'($urandom_range(255));
        it.transfer_length = CNT_W'($urandom_range(65535));
        it.stop_at_end     = 1'($urandom_range(1));
        it.data_byte       = DATA_W'($urandom_range(255));
        return it;
    endfunction

    task automatic send_event(input logic [CMD_W-1:0] cmd);
        send_item(rand_item(cmd));
    endtask

    task automatic directed(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                            input logic [CNT_W-1:0] len, input logic stop,
                            input logic [DATA_W-1:0] data);
        item_t it;
        it.command         = cmd;
        it.device_address  = addr;
        it.transfer_length = len;
        it.stop_at_end     = stop;
        it.data_byte       = data;
        send_item(it);
    endtask

    // APB write: setup then access phase
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready) @(negedge clk);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_notify(value[0]);
    endtask

    // Stop offering and wait for every outstanding result item
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() > 0) @(posedge clk);
    endtask

    function automatic logic [CMD_W-1:0] error_event();
        int r;
        r = $urandom_range(5);
        case (r)
            0: return CMD_PHY_ERROR;
            1: return CMD_BUS_ERROR;
            2: return CMD_UNKNOWN;
            default: return CMD_W'(CMD_UNKNOWN + r);
        endcase
    endfunction

    // Mostly short transfers, now and then a long one that gets cut off
    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(5);
        if (r < 95) return $urandom_range(20, 6);
        return $urandom_range(65535);
    endfunction

    // One well-formed transfer with random content, sometimes broken or noisy
    task automatic random_transfer();
        logic [CMD_W-1:0] steps[$];
        item_t            start;
        int               kind;
        int               len;
        int               nbytes;
        int               cut;
        kind = $urandom_range(99);
        len  = pick_length();
        nbytes = (len > MAX_BURST) ? MAX_BURST : len;
        if (kind >= 85) begin
            repeat ($urandom_range(3, 1)) send_event(CMD_W'($urandom_range(15)));
            return;
        end
        steps.push_back(CMD_START_SENT);
        if (kind < 40) begin
            start = rand_item(CMD_READ);
            steps.push_back(CMD_RX_MODE);
            repeat ((nbytes == 0) ? 1 : nbytes) steps.push_back(CMD_BYTE_RECEIVED);
            if ($urandom_range(9) == 0) steps.push_back(CMD_BYTE_RECEIVED);
        end else if (kind < 70) begin
            start = rand_item(CMD_WRITE);
            steps.push_back(CMD_TX_MODE);
            if (nbytes > 1) repeat (nbytes - 1) steps.push_back(CMD_TX_EMPTY);
            if ($urandom_range(9) == 0) steps.push_back(CMD_TX_EMPTY);
            steps.push_back(CMD_BYTE_SENT);
        end else begin
            start = rand_item(CMD_PROBE);
            steps.push_back(CMD_TX_MODE);
        end
        start.transfer_length = CNT_W'(len);
        // long transfers always end in an error; some others break early
        if (len > MAX_BURST) cut = steps.size();
        else if ($urandom_range(9) == 0) cut = $urandom_range(steps.size() - 1);
        else cut = -1;
        send_item(start);
        foreach (steps[i]) begin
            if (i == cut) break;
            if ($urandom_range(99) < 6) send_event(CMD_W'($urandom_range(15)));
            send_event(steps[i]);
        end
        if (cut >= 0 && ($urandom_range(3) != 0 || len > MAX_BURST)) send_event(error_event());
    endtask

    // Receiver: random stalls, one long hold-off when asked
    initial begin
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_stall <= gaps_on && ($urandom_range(99) < 32);
            end
        end
    end

    // Result monitor: values seen here are the ones taken at the next rising edge
    always @(negedge clk) begin : result_monitor
        result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.reply_code      = reply_code;
            got.start_condition = start_condition;
            got.send_address    = send_address;
            got.address_out     = address_out;
            got.send_byte       = send_byte;
            got.store_byte      = store_byte;
            got.byte_out        = byte_out;
            got.generate_stop   = generate_stop;
            got.ack_action      = ack_t'(ack_action);
            got.bus_reset       = bus_reset;
            got.done_res        = done_res;
            got.done_result     = done_t'(done_result);
            board.check_result(got);
        end
    end

    // Watchdog: cycles with no item moving on either channel
    initial begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_valid        <= 1'b0;
        command         <= '0;
        device_address  <= '0;
        transfer_length <= '0;
        stop_at_end     <= 1'b0;
        data_byte       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, notifications on
        write_reg(APB_ADDR_W'({REG_NOTIFY_ENABLE, 2'b00}), 32'd1);
        // events while idle
        directed(CMD_PHY_ERROR, 8'h00, 16'h0000, 1'b0, 8'h00);
        directed(CMD_BYTE_SENT, 8'hFF, 16'hFFFF, 1'b1, 8'hFF);
        directed(CMD_BYTE_RECEIVED, 8'h00, 16'h0000, 1'b1, 8'hFF);
        directed(CMD_TX_MODE, 8'hFF, 16'hFFFF, 1'b0, 8'h5A);
        directed(CMD_IGNORED, 8'hA5, 16'h5A5A, 1'b1, 8'hA5);
        // probe, with a start refused as busy
        directed(CMD_PROBE, 8'h00, 16'h1234, 1'b0, 8'h00);
        directed(CMD_READ, 8'hFF, 16'hFFFF, 1'b1, 8'hFF);
        directed(CMD_START_SENT, 8'h00, 16'h0000, 1'b0, 8'h00);
        directed(CMD_TX_MODE, 8'h00, 16'h0000, 1'b0, 8'h33);
        // one-byte read: ack disabled from the start
        directed(CMD_READ, 8'hFF, 16'h0001, 1'b1, 8'h00);
        directed(CMD_START_SENT, 8'h00, 16'h0000, 1'b0, 8'h00);
        directed(CMD_RX_MODE, 8'h00, 16'h0000, 1'b0, 8'h00);
        directed(CMD_BYTE_RECEIVED, 8'h00, 16'h0000, 1'b0, 8'hFF);
        // zero-length read: received byte with no count left
        directed(CMD_READ, 8'h00, 16'h0000, 1'b0, 8'h00);
        directed(CMD_RX_MODE, 8'h00, 16'h0000, 1'b0, 8'h00);
        directed(CMD_BYTE_RECEIVED, 8'h00, 16'h0000, 1'b0, 8'hA5);
        // two-byte write
        directed(CMD_WRITE, 8'h00, 16'h0002, 1'b1, 8'h00);
        directed(CMD_START_SENT, 8'h00, 16'h0000, 1'b0, 8'h00);
        directed(CMD_TX_MODE, 8'h00, 16'h0000, 1'b0, 8'h00);
        directed(CMD_TX_EMPTY, 8'h00, 16'h0000, 1'b0, 8'hFF);
        directed(CMD_BYTE_SENT, 8'h00, 16'h0000, 1'b0, 8'h00);
        // aborts of every kind
        directed(CMD_READ, 8'h5A, 16'hFFFF, 1'b0, 8'h00);
        directed(CMD_BUS_ERROR, 8'h00, 16'h0000, 1'b0, 8'h00);
        directed(CMD_WRITE, 8'hFF, 16'hFFFF, 1'b0, 8'h00);
        directed(CMD_UNKNOWN, 8'h00, 16'h0000, 1'b0, 8'h00);
        directed(CMD_PROBE, 8'hA5, 16'h0000, 1'b0, 8'h00);
        directed(CMD_PHY_ERROR, 8'h00, 16'h0000, 1'b0, 8'h00);
        directed(CMD_READ, 8'h81, 16'h0002, 1'b1, 8'h00);
        directed(CMD_ABOVE_TABLE, 8'h00, 16'h0000, 1'b0, 8'h00);
        drain();

        // Random, notifications off
        write_reg(APB_ADDR_W'({REG_NOTIFY_ENABLE, 2'b00}), 32'd0);
        while (items_sent < 160) random_transfer();
        drain();

        // Random, no idling on either side, one long receiver hold-off
        write_reg(APB_ADDR_W'({REG_NOTIFY_ENABLE, 2'b00}), 32'd1);
        gaps_on = 1'b0;
        hold_go <= 1'b1;
        while (items_sent < 300) random_transfer();
        drain();

        // Random, idling back on
        gaps_on = 1'b1;
        write_reg(APB_ADDR_W'({REG_NOTIFY_ENABLE, 2'b00}), APB_DATA_W'($urandom_range(1)));
        while (items_sent < 430) random_transfer();
        drain();

        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
